FILE: rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Codes, widths and shared types for the pool allocator and its parts.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Fixed field widths of the request and result items.
    localparam int FUNC_W    = 2;
    localparam int POOL_ID_W = 3;
    localparam int BLOCK_W   = 10;
    localparam int CAP_W     = 11;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 32;

    // Configuration port geometry: eight 32-bit capacity registers.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Capacity of every pool after reset, before clamping.
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd256;

    // Request functions.
    localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Capacity write event from the register block to the pool logic.
    typedef struct packed {
        logic                 valid;
        logic [POOL_ID_W-1:0] pool;
        logic [CAP_W-1:0]     cap;
    } t_cfg_wr;

    // Saturate a capacity value to the number of blocks a pool can hold.
    function automatic logic [CAP_W-1:0] clamp_cap(logic [CAP_W-1:0] v, int max_blocks);
        logic [CAP_W-1:0] res;
        if (32'(v) > max_blocks) begin
            res = CAP_W'(max_blocks);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: rtl/fbpa_stack_mem.sv
// ----------------------------------------------------------------------------
// Free stack memory
// Simple dual-port synchronous RAM holding the free block stacks of all
// pools; one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_stack_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fbpa_apb.sv
// ----------------------------------------------------------------------------
// Capacity register block
// APB-style slave holding one clamped capacity register per pool and
// signaling each capacity write so the pool can be reinitialized.
// ----------------------------------------------------------------------------
module fbpa_apb import fbpa_pkg::*; #(
    parameter int POOL_COUNT = 8,
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CAP_W-1:0]      o_cap [POOL_COUNT],
    output t_cfg_wr               o_cfg_wr
);

    localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

    logic [CAP_W-1:0]     r_cap [POOL_COUNT];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_ok;
    logic                 wr_strobe;
    logic [CAP_W-1:0]     wr_cap;

    // Address decode; registers beyond the pool count are not present.
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign reg_ok    = (32'(reg_idx) < POOL_COUNT);
    assign wr_strobe = psel && penable && pwrite && reg_ok;
    assign wr_cap    = clamp_cap(pwdata[CAP_W-1:0], MAX_BLOCKS);
    assign pready    = 1'b1;

    // Capacity registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POOL_COUNT; p++) begin
                r_cap[p] <= clamp_cap(CAP_RESET, MAX_BLOCKS);
            end
        end else if (wr_strobe) begin
            r_cap[PW'(reg_idx)] <= wr_cap;
        end
    end

    // Read data and write event.
    always_comb begin
        prdata = '0;
        if (reg_ok) begin
            prdata = APB_DATA_W'(r_cap[PW'(reg_idx)]);
        end
        o_cfg_wr.valid = wr_strobe;
        o_cfg_wr.pool  = reg_idx;
        o_cfg_wr.cap   = wr_cap;
    end

    assign o_cap = r_cap;

endmodule

FILE: rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Independent pools of fixed-size blocks, each with a LIFO free stack and
// usage counters; serves acquire, release, stats read and stats clear.
// ----------------------------------------------------------------------------
// Usage:
// Request items (func, pool_id, block_index) enter on the input channel and
// each one produces exactly one result item on the output channel. An item
// is taken when i_in_valid is high and o_in_stall is low; a result is taken
// when o_out_valid is high and i_out_stall is low.
// An accepted item issues its free stack read in the accept cycle, is
// executed in the following cycle, and its result is registered at the end
// of execution. No new item is taken while one executes: the stack memory
// read latency is interlocked against the next item's stack pointer.
// A waiting result sits in the output register; the next item is accepted
// in the cycle that result is taken, and stalls while it is held.
// After reset every pool holds blocks 0 to capacity-1 with capacity 256
// (clamped to MAX_BLOCKS) and all counters are zero. No memory clearing
// pass is needed: a per-pool low-water mark tells which stack entries were
// never written, and those read back as their own position. A capacity
// write through the APB port reinitializes that pool.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int POOL_COUNT = 8,
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [POOL_ID_W-1:0]  i_pool_id,
    input  logic [BLOCK_W-1:0]    i_block_index,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [BLOCK_W-1:0]    o_granted_block,
    output logic [CAP_W-1:0]      o_free_blocks,
    output logic [CAP_W-1:0]      o_blocks_in_use,
    output logic [CAP_W-1:0]      o_peak_use,
    output logic [TOTAL_W-1:0]    o_acquire_total,
    output logic [TOTAL_W-1:0]    o_release_total,
    output logic [TOTAL_W-1:0]    o_failure_total,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int CW    = ($clog2(MAX_BLOCKS + 1) < CAP_W) ? $clog2(MAX_BLOCKS + 1) : CAP_W;
    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int DEPTH = POOL_COUNT * MAX_BLOCKS;
    localparam int MW    = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Control state.
    t_state r_state;
    logic   r_out_valid;

    // Latched item.
    logic [FUNC_W-1:0]  r_func;
    logic [PW-1:0]      r_pool;
    logic               r_pool_ok;
    logic [BLOCK_W-1:0] r_blk;

    // Per-pool state.
    logic [CW-1:0]      r_fc    [POOL_COUNT];
    logic [CW-1:0]      r_lwm   [POOL_COUNT];
    logic [CW-1:0]      r_inuse [POOL_COUNT];
    logic [CW-1:0]      r_peak  [POOL_COUNT];
    logic [TOTAL_W-1:0] r_acq   [POOL_COUNT];
    logic [TOTAL_W-1:0] r_rel   [POOL_COUNT];
    logic [TOTAL_W-1:0] r_fail  [POOL_COUNT];

    // Result registers.
    logic [STATUS_W-1:0] r_status;
    logic [BLOCK_W-1:0]  r_granted;
    logic [CAP_W-1:0]    r_free;
    logic [CAP_W-1:0]    r_inuse_o;
    logic [CAP_W-1:0]    r_peak_o;
    logic [TOTAL_W-1:0]  r_acq_o;
    logic [TOTAL_W-1:0]  r_rel_o;
    logic [TOTAL_W-1:0]  r_fail_o;

    // Next values of the addressed pool.
    logic [CW-1:0]       n_fc;
    logic [CW-1:0]       n_lwm;
    logic [CW-1:0]       n_inuse;
    logic [CW-1:0]       n_peak;
    logic [TOTAL_W-1:0]  n_acq;
    logic [TOTAL_W-1:0]  n_rel;
    logic [TOTAL_W-1:0]  n_fail;
    logic [STATUS_W-1:0] n_status;
    logic [BLOCK_W-1:0]  n_granted;

    logic [CAP_W-1:0]   cap [POOL_COUNT];
    t_cfg_wr            cfg_wr;
    logic [PW-1:0]      cfg_pool;
    logic [CW-1:0]      cfg_cap;
    logic               in_accept;
    logic               in_pool_ok;
    logic [PW-1:0]      in_pool;
    logic [AW-1:0]      rd_pos;
    logic [AW-1:0]      pop_pos;
    logic [MW-1:0]      mem_raddr;
    logic               mem_re;
    logic               mem_we;
    logic [MW-1:0]      mem_waddr;
    logic [BLOCK_W-1:0] mem_rdata;
    logic               do_exec;
    logic [CW-1:0]      cap_init;

    assign cap_init = CW'(clamp_cap(CAP_RESET, MAX_BLOCKS));

    // Capacity registers and configuration port.
    fbpa_apb #(
        .POOL_COUNT(POOL_COUNT),
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cap    (cap),
        .o_cfg_wr (cfg_wr)
    );

    assign cfg_pool = PW'(cfg_wr.pool);
    assign cfg_cap  = CW'(cfg_wr.cap);

    // Input handshake: one item in flight, the output register must be free or being taken.
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_pool_ok = (32'(i_pool_id) < POOL_COUNT);
    assign in_pool    = in_pool_ok ? PW'(i_pool_id) : '0;
    assign do_exec    = (r_state == S_EXEC);

    // Stack read at the top entry of the addressed pool, issued at acceptance.
    assign rd_pos    = AW'(r_fc[in_pool] - 1'b1);
    assign mem_re    = in_accept && in_pool_ok && (i_func == FN_ACQUIRE);
    assign mem_raddr = MW'(in_pool) * MW'(MAX_BLOCKS) + MW'(rd_pos);

    fbpa_stack_mem #(
        .DEPTH (DEPTH),
        .ADDR_W(MW),
        .DATA_W(BLOCK_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_blk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Execute the latched item against the addressed pool.
    always_comb begin
        n_fc      = r_fc[r_pool];
        n_lwm     = r_lwm[r_pool];
        n_inuse   = r_inuse[r_pool];
        n_peak    = r_peak[r_pool];
        n_acq     = r_acq[r_pool];
        n_rel     = r_rel[r_pool];
        n_fail    = r_fail[r_pool];
        n_status  = ST_OK;
        n_granted = '0;
        pop_pos   = AW'(r_fc[r_pool] - 1'b1);
        mem_we    = 1'b0;
        mem_waddr = MW'(r_pool) * MW'(MAX_BLOCKS) + MW'(AW'(r_fc[r_pool]));
        case (r_func)
            FN_ACQUIRE: begin
                if (r_fc[r_pool] == '0) begin
                    n_fail   = r_fail[r_pool] + 1'b1;
                    n_status = ST_EMPTY;
                end else begin
                    n_fc = r_fc[r_pool] - 1'b1;
                    // An entry below the low-water mark was never written
                    // since the pool was set up and still holds its position.
                    if (n_fc < r_lwm[r_pool]) begin
                        n_granted = BLOCK_W'(pop_pos);
                        n_lwm     = n_fc;
                    end else begin
                        n_granted = mem_rdata;
                    end
                    n_acq   = r_acq[r_pool] + 1'b1;
                    n_inuse = r_inuse[r_pool] + 1'b1;
                    if (n_inuse > r_peak[r_pool]) begin
                        n_peak = n_inuse;
                    end
                end
            end
            FN_RELEASE: begin
                if (CAP_W'(r_fc[r_pool]) >= cap[r_pool]) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we = do_exec && r_pool_ok;
                    n_fc   = r_fc[r_pool] + 1'b1;
                    n_rel  = r_rel[r_pool] + 1'b1;
                    if (r_inuse[r_pool] != '0) begin
                        n_inuse = r_inuse[r_pool] - 1'b1;
                    end
                end
            end
            FN_CLEAR: begin
                n_inuse = '0;
                n_peak  = '0;
                n_acq   = '0;
                n_rel   = '0;
                n_fail  = '0;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, item latch and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item latch.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func    <= i_func;
            r_pool    <= in_pool;
            r_pool_ok <= in_pool_ok;
            r_blk     <= i_block_index;
        end
    end

    // Result payload; an absent pool reports all zeros.
    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            if (r_pool_ok) begin
                r_status  <= n_status;
                r_granted <= n_granted;
                r_free    <= CAP_W'(n_fc);
                r_inuse_o <= CAP_W'(n_inuse);
                r_peak_o  <= CAP_W'(n_peak);
                r_acq_o   <= n_acq;
                r_rel_o   <= n_rel;
                r_fail_o  <= n_fail;
            end else begin
                r_status  <= ST_OK;
                r_granted <= '0;
                r_free    <= '0;
                r_inuse_o <= '0;
                r_peak_o  <= '0;
                r_acq_o   <= '0;
                r_rel_o   <= '0;
                r_fail_o  <= '0;
            end
        end
    end

    // Per-pool state: reset, capacity write, clear of all stats, update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POOL_COUNT; p++) begin
                r_fc[p]    <= cap_init;
                r_lwm[p]   <= cap_init;
                r_inuse[p] <= '0;
                r_peak[p]  <= '0;
                r_acq[p]   <= '0;
                r_rel[p]   <= '0;
                r_fail[p]  <= '0;
            end
        end else if (cfg_wr.valid) begin
            r_fc[cfg_pool]    <= cfg_cap;
            r_lwm[cfg_pool]   <= cfg_cap;
            r_inuse[cfg_pool] <= '0;
            r_peak[cfg_pool]  <= '0;
            r_acq[cfg_pool]   <= '0;
            r_rel[cfg_pool]   <= '0;
            r_fail[cfg_pool]  <= '0;
        end else if (do_exec && r_pool_ok) begin
            if (r_func == FN_CLEAR) begin
                for (int p = 0; p < POOL_COUNT; p++) begin
                    r_inuse[p] <= '0;
                    r_peak[p]  <= '0;
                    r_acq[p]   <= '0;
                    r_rel[p]   <= '0;
                    r_fail[p]  <= '0;
                end
            end else begin
                r_fc[r_pool]    <= n_fc;
                r_lwm[r_pool]   <= n_lwm;
                r_inuse[r_pool] <= n_inuse;
                r_peak[r_pool]  <= n_peak;
                r_acq[r_pool]   <= n_acq;
                r_rel[r_pool]   <= n_rel;
                r_fail[r_pool]  <= n_fail;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_block = r_granted;
    assign o_free_blocks   = r_free;
    assign o_blocks_in_use = r_inuse_o;
    assign o_peak_use      = r_peak_o;
    assign o_acquire_total = r_acq_o;
    assign o_release_total = r_rel_o;
    assign o_failure_total = r_fail_o;

    // The addressed pool never holds more free blocks than its capacity.
    a_fc_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_exec |-> (CAP_W'(r_fc[r_pool]) <= cap[r_pool]))
        else $error("free count above capacity");

    // The low-water mark never lies above the free count.
    a_lwm_le_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_exec |-> (r_lwm[r_pool] <= r_fc[r_pool]))
        else $error("low-water mark above free count");

    // Every executed item leaves a result in the output register.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_exec |=> o_out_valid)
        else $error("executed item left no result");

    // A stack write never coincides with an accepted item.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !in_accept)
        else $error("stack write overlaps a new item");

endmodule
